/* rtl/aes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and byte functions of the aes-128 cbc engine
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumWords   = 44;
  localparam int unsigned WordAddrW  = 6;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIvHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIvLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode    = 3'd4;

  localparam logic [1:0] ModeEcbEnc = 2'd0;
  localparam logic [1:0] ModeEcbDec = 2'd1;
  localparam logic [1:0] ModeCbcEnc = 2'd2;
  localparam logic [1:0] ModeCbcDec = 2'd3;

  typedef logic [7:0] byte_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // gf(2^8) multiply by x
  function automatic byte_t xt(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // gf(2^8) multiply modulo 0x11b
  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t p;
    byte_t x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  // inverse s-box as a flat match against the forward table
  function automatic byte_t inv_sbox(input byte_t a);
    byte_t r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(byte_t'(i)) == a) r = byte_t'(i);
    end
    return r;
  endfunction

  function automatic byte_t rcon(input logic [3:0] r);
    byte_t c;
    case (r)
      4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
      4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
      4'd9: c = 8'h1b; 4'd10: c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic       decrypt;
    logic       first;
    logic       final_rnd;
  } rnd_ctrl_t;

endpackage

/* rtl/aes_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes channel interfaces
// valid/ready channels for blocks, results and register writes
// ----------------------------------------------------------------------------
interface aes_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        last_block;
  modport source (output valid, block_high, block_low, last_block, input ready);
  modport sink   (input valid, block_high, block_low, last_block, output ready);
endinterface

interface aes_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/aes128_cbc_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_cipher
// aes-128 engine, ecb/cbc encrypt and decrypt, one round per pass
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  blk      in   block_high, block_low, last      valid/ready
//  res      out  result_high, result_low          valid/ready
//  cfg      in   index, data                      valid/ready
//
// each of the 11 passes makes 4 round-key word reads, whose data is registered
// in the key memory, then one run of the shared round unit
// the result is registered in the output register on leaving StOut; the next
// request is taken only back in StIdle, so a block is done before the next
// a key write starts the expansion of all 44 words; blocks and writes wait for it
// reset clears control and the chain; a stalled sink holds the result
// ----------------------------------------------------------------------------
module aes128_cbc_cipher (
  input  logic         clk_i,
  input  logic         rst_ni,
  aes_blk_if.sink      blk_i,
  aes_res_if.source    res_o,
  aes_cfg_if.sink      cfg_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StRnd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic [1:0]   mode_q;
  logic [127:0] chain_q, state_q, in_q, rkey_q;
  logic         restart_q, last_q, out_v_q;
  logic [127:0] out_q;
  logic [1:0]   st_q;
  logic [3:0]   rnd_q;   // pass number 0..10
  logic [2:0]   wrd_q;   // word fetch step 0..4
  logic         exp_busy;
  logic         exp_start;
  logic [5:0]   rd_addr;
  logic [31:0]  rd_data;
  logic [127:0] rnd_out;
  logic         dec;
  logic [3:0]   key_row;
  logic         out_take;
  aes_pkg::rnd_ctrl_t ctrl;

  assign dec = mode_q[0];
  assign key_row = dec ? 4'd10 - rnd_q : rnd_q;
  assign rd_addr = {key_row, wrd_q[1:0]};

  // a waiting block request goes first, so a write never lands with a block
  assign cfg_i.ready = (st_q == StIdle) && !exp_busy && !blk_i.valid;
  assign exp_start = cfg_i.valid && cfg_i.ready &&
                     (cfg_i.index == aes_pkg::RegKeyHigh ||
                      cfg_i.index == aes_pkg::RegKeyLow);
  assign blk_i.ready = (st_q == StIdle) && !exp_busy;
  assign res_o.valid = out_v_q;
  assign res_o.result_high = out_q[127:64];
  assign res_o.result_low  = out_q[63:0];

  // finished block moves into the output register once it is free
  assign out_take = (st_q == StOut) && (!out_v_q || res_o.ready);

  aes_key_exp u_kexp (
    .clk_i, .rst_ni,
    .start_i   (exp_start),
    .key_high_i(cfg_i.index == aes_pkg::RegKeyHigh ? cfg_i.data : key_hi_q),
    .key_low_i (cfg_i.index == aes_pkg::RegKeyLow  ? cfg_i.data : key_lo_q),
    .busy_o    (exp_busy),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    ctrl.decrypt   = dec;
    ctrl.first     = (rnd_q == 4'd0);
    ctrl.final_rnd = (rnd_q == 4'd10);
  end

  aes_round u_rnd (.ctrl_i(ctrl), .state_i(state_q), .rkey_i(rkey_q), .state_o(rnd_out));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; rnd_q <= '0; wrd_q <= '0; out_v_q <= 1'b0;
      restart_q <= 1'b1; mode_q <= aes_pkg::ModeEcbEnc;
      key_hi_q <= '0; key_lo_q <= '0; iv_hi_q <= '0; iv_lo_q <= '0;
      chain_q <= '0; rkey_q <= '0; out_q <= '0;
    end else begin
      if (out_take) out_v_q <= 1'b1;
      else if (res_o.valid && res_o.ready) out_v_q <= 1'b0;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          aes_pkg::RegKeyHigh: key_hi_q <= cfg_i.data;
          aes_pkg::RegKeyLow:  key_lo_q <= cfg_i.data;
          aes_pkg::RegIvHigh:  iv_hi_q  <= cfg_i.data;
          aes_pkg::RegIvLow:   iv_lo_q  <= cfg_i.data;
          aes_pkg::RegMode:    mode_q   <= cfg_i.data[1:0];
          default: ;
        endcase
      end
      case (st_q)
        StIdle: if (blk_i.valid && blk_i.ready) begin
          st_q <= StLoad; rnd_q <= '0; wrd_q <= '0;
          if (mode_q[1] && restart_q) chain_q <= {iv_hi_q, iv_lo_q};
        end
        StLoad: begin
          // read data is registered, so it arrives the cycle after its address
          if (wrd_q != 3'd0) rkey_q <= {rkey_q[95:0], rd_data};
          if (wrd_q == 3'd4) begin
            st_q <= StRnd; wrd_q <= '0;
          end else wrd_q <= wrd_q + 3'd1;
        end
        StRnd: begin
          if (rnd_q == 4'd10) st_q <= StOut;
          else begin
            rnd_q <= rnd_q + 4'd1; st_q <= StLoad;
          end
        end
        StOut: if (out_take) begin
          st_q <= StIdle;
          case (mode_q)
            aes_pkg::ModeCbcEnc: begin
              out_q <= state_q; chain_q <= state_q; restart_q <= last_q;
            end
            aes_pkg::ModeCbcDec: begin
              out_q <= state_q ^ chain_q; chain_q <= in_q; restart_q <= last_q;
            end
            default: out_q <= state_q;
          endcase
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // block capture with cbc-encrypt chaining folded in, then one round per pass
  always_ff @(posedge clk_i) begin
    if (blk_i.valid && blk_i.ready) begin
      in_q   <= {blk_i.block_high, blk_i.block_low};
      last_q <= blk_i.last_block;
      if (mode_q == aes_pkg::ModeCbcEnc)
        state_q <= {blk_i.block_high, blk_i.block_low} ^
                   (restart_q ? {iv_hi_q, iv_lo_q} : chain_q);
      else state_q <= {blk_i.block_high, blk_i.block_low};
    end else if (st_q == StRnd) begin
      state_q <= rnd_out;
    end
  end

endmodule

/* rtl/aes_key_exp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_key_exp
// round-key expansion, one word a cycle, into a 44-word memory
// ----------------------------------------------------------------------------
module aes_key_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  output logic        busy_o,
  input  logic [5:0]  rd_addr_i,
  output logic [31:0] rd_data_o
);

  logic [31:0] mem [aes_pkg::NumWords];
  logic [5:0]  idx_q, idx_d;
  logic        busy_q, busy_d;
  logic [31:0] w4 [4];      // words i-4..i-1 window
  logic [127:0] win_q, win_d;
  logic [31:0] t, nw;

  assign w4[0] = win_q[127:96];
  assign w4[1] = win_q[95:64];
  assign w4[2] = win_q[63:32];
  assign w4[3] = win_q[31:0];

  always_comb begin
    t = w4[3];
    if (idx_q[1:0] == 2'd0) begin
      t = {aes_pkg::sbox(w4[3][23:16]) ^ aes_pkg::rcon(idx_q[5:2]),
           aes_pkg::sbox(w4[3][15:8]), aes_pkg::sbox(w4[3][7:0]),
           aes_pkg::sbox(w4[3][31:24])};
    end
    nw = w4[0] ^ t;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    win_d  = win_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = 6'd0;
      win_d  = {key_high_i, key_low_i};
    end else if (busy_q) begin
      if (idx_q >= 6'd4) win_d = {win_q[95:0], nw};
      idx_d = idx_q + 6'd1;
      if (idx_q == 6'(aes_pkg::NumWords - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (busy_q && !start_i) begin
      if (idx_q < 6'd4) mem[idx_q] <= win_q[127 - 32*idx_q[1:0] -: 32];
      else mem[idx_q] <= nw;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  assign busy_o = busy_q;

endmodule

/* rtl/aes_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round
// shared round unit: one forward or inverse round, or the first key addition, per cycle
// ----------------------------------------------------------------------------
module aes_round (
  input  aes_pkg::rnd_ctrl_t ctrl_i,
  input  logic [127:0]       state_i,
  input  logic [127:0]       rkey_i,
  output logic [127:0]       state_o
);

  aes_pkg::byte_t s [16];
  aes_pkg::byte_t t [16];
  aes_pkg::byte_t m [16];
  aes_pkg::byte_t k [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127 - 8*i -: 8];
      k[i] = rkey_i[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl_i.decrypt) t[c*4+r] = aes_pkg::inv_sbox(s[((c - r + 4) % 4)*4 + r]);
        else t[c*4+r] = aes_pkg::sbox(s[((c + r) % 4)*4 + r]);
      end
    end
    for (int i = 0; i < 16; i++) m[i] = t[i];
    if (ctrl_i.decrypt) begin
      for (int i = 0; i < 16; i++) t[i] = t[i] ^ k[i];
      for (int c = 0; c < 4; c++) begin
        m[c*4]   = aes_pkg::gmul(t[c*4],8'd14)^aes_pkg::gmul(t[c*4+1],8'd11)
                 ^ aes_pkg::gmul(t[c*4+2],8'd13)^aes_pkg::gmul(t[c*4+3],8'd9);
        m[c*4+1] = aes_pkg::gmul(t[c*4],8'd9)^aes_pkg::gmul(t[c*4+1],8'd14)
                 ^ aes_pkg::gmul(t[c*4+2],8'd11)^aes_pkg::gmul(t[c*4+3],8'd13);
        m[c*4+2] = aes_pkg::gmul(t[c*4],8'd13)^aes_pkg::gmul(t[c*4+1],8'd9)
                 ^ aes_pkg::gmul(t[c*4+2],8'd14)^aes_pkg::gmul(t[c*4+3],8'd11);
        m[c*4+3] = aes_pkg::gmul(t[c*4],8'd11)^aes_pkg::gmul(t[c*4+1],8'd13)
                 ^ aes_pkg::gmul(t[c*4+2],8'd9)^aes_pkg::gmul(t[c*4+3],8'd14);
      end
      if (ctrl_i.final_rnd) for (int i = 0; i < 16; i++) m[i] = t[i];
    end else begin
      if (!ctrl_i.final_rnd) begin
        for (int c = 0; c < 4; c++) begin
          m[c*4]   = aes_pkg::xt(t[c*4]) ^ aes_pkg::xt(t[c*4+1]) ^ t[c*4+1]
                   ^ t[c*4+2] ^ t[c*4+3];
          m[c*4+1] = t[c*4] ^ aes_pkg::xt(t[c*4+1]) ^ aes_pkg::xt(t[c*4+2])
                   ^ t[c*4+2] ^ t[c*4+3];
          m[c*4+2] = t[c*4] ^ t[c*4+1] ^ aes_pkg::xt(t[c*4+2])
                   ^ aes_pkg::xt(t[c*4+3]) ^ t[c*4+3];
          m[c*4+3] = aes_pkg::xt(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2]
                   ^ aes_pkg::xt(t[c*4+3]);
        end
      end
      for (int i = 0; i < 16; i++) m[i] = m[i] ^ k[i];
    end
    for (int i = 0; i < 16; i++) state_o[127 - 8*i -: 8] = m[i];
    if (ctrl_i.first) state_o = state_i ^ rkey_i;
  end

endmodule

/* rtl/aes_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_checker
// port-level checks of the aes engine, bound to the top level
// ----------------------------------------------------------------------------
module aes_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic blk_valid_i, blk_ready_i,
  input logic res_valid_i, res_ready_i,
  input logic cfg_ready_i
);
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i) else $error("result dropped");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_i && blk_ready_i |=> !blk_ready_i) else $error("took two blocks");
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_i && blk_ready_i |=> !cfg_ready_i) else $error("cfg open mid block");
  a_no_early_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_i && blk_ready_i && !res_valid_i |=> !res_valid_i)
    else $error("early result");
endmodule

bind aes128_cbc_cipher aes_checker u_chk (
  .clk_i, .rst_ni,
  .blk_valid_i(blk_i.valid), .blk_ready_i(blk_i.ready),
  .res_valid_i(res_o.valid), .res_ready_i(res_o.ready),
  .cfg_ready_i(cfg_i.ready)
);
